// File: rtl/markov_chain_note_sampler_assert.svh
// assertion macros for the note sampler
`ifndef MARKOV_CHAIN_NOTE_SAMPLER_ASSERT_SVH
`define MARKOV_CHAIN_NOTE_SAMPLER_ASSERT_SVH

`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define MCNS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mcns assertion failed");
// consequent must hold in the cycle after the antecedent
`define MCNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcns assertion failed");
`else
`define MCNS_ASSERT(lbl, clk, rst_n, prop)
`define MCNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/mcns_pkg.sv
`timescale 1ns / 1ps
package mcns_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLUMNS = 64;
    localparam int PROB_BITS   = 16;
    localparam int NOTE_BITS   = 10;

    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int COL_AW   = $clog2(MAX_COLUMNS);
    localparam int PROB_AW  = ROW_AW + COL_AW;
    localparam int SUM_BITS = PROB_BITS + COL_AW;

    localparam int ROWCNT_W = 8;
    localparam int COLCNT_W = 7;
    localparam int CFG_W    = 8;

    typedef logic [NOTE_BITS-1:0] t_note;

    typedef struct packed {
        t_note older;
        t_note newer;
    } t_label;

    typedef struct packed {
        logic               we;
        logic [PROB_AW-1:0] waddr;
        logic [PROB_BITS-1:0] wdata;
        logic               re;
        logic [PROB_AW-1:0] raddr;
    } t_prob_port;

    typedef struct packed {
        logic              we;
        logic [COL_AW-1:0] waddr;
        t_note             wdata;
        logic              re;
        logic [COL_AW-1:0] raddr;
    } t_col_port;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] waddr;
        t_label            wdata;
        logic              re;
        logic [ROW_AW-1:0] raddr;
    } t_lbl_port;

    typedef struct packed {
        t_note      first;
        t_note      second;
        logic [1:0] count;
        logic [1:0] status;
    } t_result;

    typedef enum logic [2:0] {
        ACT_LOAD_PROB = 3'd0,
        ACT_LOAD_ROW  = 3'd1,
        ACT_LOAD_COL  = 3'd2,
        ACT_GENERATE  = 3'd3,
        ACT_RESTART   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_LDATA,
        ST_SCAN,
        ST_NOTE,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_NOT_REACHED = 2'd1;
    localparam logic [1:0] STAT_NO_ROW      = 2'd2;

    localparam logic [1:0] CFG_CHAIN_ORDER = 2'd0;
    localparam logic [1:0] CFG_ROWS        = 2'd1;
    localparam logic [1:0] CFG_COLS        = 2'd2;

    localparam logic [1:0] ORDER_SECOND = 2'd2;

endpackage

// File: rtl/mcns_prob_store.sv
`timescale 1ns / 1ps
module mcns_prob_store (
    input  logic                          i_clk,
    input  mcns_pkg::t_prob_port          i_prob,
    input  mcns_pkg::t_col_port           i_col,
    output logic [mcns_pkg::PROB_BITS-1:0] o_prob_rdata,
    output mcns_pkg::t_note               o_col_rdata
);
    import mcns_pkg::*;

    logic [PROB_BITS-1:0] r_prob_mem [MAX_ROWS*MAX_COLUMNS];
    t_note                r_col_mem  [MAX_COLUMNS];
    logic [PROB_BITS-1:0] r_prob_rdata;
    t_note                r_col_rdata;

    // read data holds until the next read of the same port
    always_ff @(posedge i_clk) begin
        if (i_prob.we) begin
            r_prob_mem[i_prob.waddr] <= i_prob.wdata;
        end
        if (i_prob.re) begin
            r_prob_rdata <= r_prob_mem[i_prob.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_col.we) begin
            r_col_mem[i_col.waddr] <= i_col.wdata;
        end
        if (i_col.re) begin
            r_col_rdata <= r_col_mem[i_col.raddr];
        end
    end

    assign o_prob_rdata = r_prob_rdata;
    assign o_col_rdata  = r_col_rdata;

endmodule

// File: rtl/mcns_label_store.sv
`timescale 1ns / 1ps
module mcns_label_store (
    input  logic                i_clk,
    input  mcns_pkg::t_lbl_port i_lbl,
    output mcns_pkg::t_label    o_rdata
);
    import mcns_pkg::*;

    t_label r_lbl_mem [MAX_ROWS];
    t_label r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_lbl.we) begin
            r_lbl_mem[i_lbl.waddr] <= i_lbl.wdata;
        end
        if (i_lbl.re) begin
            r_rdata <= r_lbl_mem[i_lbl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/markov_chain_note_sampler.sv
`timescale 1ns / 1ps
// Markov chain note sampler.
// Input channel i_valid / o_ready carries one item per handshake: loads of the
// probability table, row labels and column labels, generate items and restart.
// Output channel o_valid / i_ready carries one result per generate item only.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, one
// register per cycle; the user writes it only while no generate item is in
// progress, a rule the block leaves unchecked. Loads and restart are done at
// acceptance and may follow back to back. ST_EMIT registers every result.
// Generate without history: ST_PICK reads the start row label, ST_LDATA
// builds the result. Generate with history: ST_SCAN reads the probability
// memory one column a cycle until the sum reaches the threshold (at most
// columns_in_use), ST_NOTE takes the note, ST_SEARCH reads the row label
// memory one row a cycle over rows_in_use; a short sum goes to ST_EMIT.
// o_ready stays low from a generate item until its result is in the output
// register; that register holds while the receiver stalls, and a new item is
// taken meanwhile, but a further result waits until the register is free.
// Reset clears history and o_valid and resets the configuration; the tables
// are not cleared and must be loaded before use, there is no clearing pass.
module markov_chain_note_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [mcns_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_action,
    input  logic [mcns_pkg::ROWCNT_W-1:0] i_row_index,
    input  logic [mcns_pkg::COLCNT_W-1:0] i_column_index,
    input  logic [mcns_pkg::PROB_BITS-1:0] i_probability,
    input  logic [mcns_pkg::NOTE_BITS-1:0] i_label_note,
    input  logic [mcns_pkg::NOTE_BITS-1:0] i_label_second_note,
    input  logic [mcns_pkg::PROB_BITS-1:0] i_random_fraction,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mcns_pkg::NOTE_BITS-1:0] o_first_note,
    output logic [mcns_pkg::NOTE_BITS-1:0] o_second_note,
    output logic [1:0]                    o_note_count,
    output logic [1:0]                    o_status
);
    import mcns_pkg::*;

    `include "markov_chain_note_sampler_assert.svh"

    // configuration
    logic [1:0]          r_chain_order;
    logic [ROWCNT_W-1:0] r_rows_in_use;
    logic [COLCNT_W-1:0] r_cols_in_use;
    logic [ROWCNT_W-1:0] rows_eff;
    logic [COLCNT_W-1:0] cols_eff;
    logic                second;

    // control and working registers
    t_state               r_state, n_state;
    logic                 r_hist, n_hist;
    logic [ROW_AW-1:0]    r_cur_row, n_cur_row;
    logic [PROB_BITS-1:0] r_thresh, n_thresh;
    logic [SUM_BITS-1:0]  r_sum, n_sum;
    logic [COL_AW-1:0]    r_dcol, n_dcol;
    logic [ROW_AW-1:0]    r_si, n_si;
    t_note                r_note, n_note;
    t_note                r_prev_newer, n_prev_newer;
    logic [ROW_AW-1:0]    r_found, n_found;
    logic                 r_found_v, n_found_v;
    t_result              r_res, n_res;
    logic                 r_o_valid, n_o_valid;
    t_result              r_o, n_o;

    // memory ports
    t_prob_port           prob_port;
    t_col_port            col_port;
    t_lbl_port            lbl_port;
    logic [PROB_BITS-1:0] prob_rdata;
    t_note                col_rdata;
    t_label               lbl_rdata;

    // datapath helpers
    logic [ROWCNT_W-1:0]          ri_m1;
    logic [COLCNT_W-1:0]          ci_m1;
    logic                         row_ok, col_ok;
    logic [PROB_BITS+ROWCNT_W-1:0] pick_prod;
    logic [ROW_AW-1:0]            pick;
    logic [SUM_BITS-1:0]          sum_next;
    logic [COL_AW-1:0]            dcol_nxt;
    logic [ROW_AW-1:0]            si_nxt;
    logic                         lbl_hit;
    logic                         found_v;
    logic [ROW_AW-1:0]            found_idx;

    mcns_prob_store u_prob_store (
        .i_clk       (i_clk),
        .i_prob      (prob_port),
        .i_col       (col_port),
        .o_prob_rdata(prob_rdata),
        .o_col_rdata (col_rdata)
    );

    mcns_label_store u_label_store (
        .i_clk  (i_clk),
        .i_lbl  (lbl_port),
        .o_rdata(lbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_order <= 2'd1;
            r_rows_in_use <= ROWCNT_W'(1);
            r_cols_in_use <= COLCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHAIN_ORDER: r_chain_order <= i_cfg_data[1:0];
                CFG_ROWS:        r_rows_in_use <= i_cfg_data[ROWCNT_W-1:0];
                CFG_COLS:        r_cols_in_use <= i_cfg_data[COLCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_rows_in_use == '0) begin
            rows_eff = ROWCNT_W'(1);
        end else if (r_rows_in_use > ROWCNT_W'(MAX_ROWS)) begin
            rows_eff = ROWCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = r_rows_in_use;
        end
        if (r_cols_in_use == '0) begin
            cols_eff = COLCNT_W'(1);
        end else if (r_cols_in_use > COLCNT_W'(MAX_COLUMNS)) begin
            cols_eff = COLCNT_W'(MAX_COLUMNS);
        end else begin
            cols_eff = r_cols_in_use;
        end
    end

    assign second = (r_chain_order == ORDER_SECOND);

    assign ri_m1  = i_row_index - ROWCNT_W'(1);
    assign ci_m1  = i_column_index - COLCNT_W'(1);
    assign row_ok = (i_row_index != '0) && (i_row_index <= ROWCNT_W'(MAX_ROWS));
    assign col_ok = (i_column_index != '0) && (i_column_index <= COLCNT_W'(MAX_COLUMNS));

    // start row: floor(r * rows / 2^PROB_BITS), always below rows
    assign pick_prod = {{ROWCNT_W{1'b0}}, i_random_fraction}
                     * {{PROB_BITS{1'b0}}, rows_eff};
    assign pick      = pick_prod[PROB_BITS +: ROW_AW];

    assign sum_next = r_sum + SUM_BITS'(prob_rdata);
    assign dcol_nxt = r_dcol + COL_AW'(1);
    assign si_nxt   = r_si + ROW_AW'(1);

    assign lbl_hit   = second ? ((lbl_rdata.older == r_prev_newer) && (lbl_rdata.newer == r_note))
                              : (lbl_rdata.older == r_note);
    // last matching row wins
    assign found_v   = r_found_v || lbl_hit;
    assign found_idx = lbl_hit ? r_si : r_found;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_hist       = r_hist;
        n_cur_row    = r_cur_row;
        n_thresh     = r_thresh;
        n_sum        = r_sum;
        n_dcol       = r_dcol;
        n_si         = r_si;
        n_note       = r_note;
        n_prev_newer = r_prev_newer;
        n_found      = r_found;
        n_found_v    = r_found_v;
        n_res        = r_res;
        n_o          = r_o;
        n_o_valid    = r_o_valid;
        prob_port    = '0;
        col_port     = '0;
        lbl_port     = '0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (t_action'(i_action))
                        ACT_LOAD_PROB: begin
                            prob_port.we    = row_ok && col_ok;
                            prob_port.waddr = {ri_m1[ROW_AW-1:0], ci_m1[COL_AW-1:0]};
                            prob_port.wdata = i_probability;
                        end
                        ACT_LOAD_ROW: begin
                            lbl_port.we    = row_ok;
                            lbl_port.waddr = ri_m1[ROW_AW-1:0];
                            lbl_port.wdata = '{older: i_label_note,
                                               newer: i_label_second_note};
                        end
                        ACT_LOAD_COL: begin
                            col_port.we    = col_ok;
                            col_port.waddr = ci_m1[COL_AW-1:0];
                            col_port.wdata = i_label_note;
                        end
                        ACT_RESTART: begin
                            n_hist    = 1'b0;
                            n_cur_row = '0;
                        end
                        ACT_GENERATE: begin
                            n_thresh = i_random_fraction;
                            if (!r_hist) begin
                                n_cur_row = pick;
                                n_hist    = 1'b1;
                                n_state   = ST_PICK;
                            end else begin
                                // first column and the current row label
                                prob_port.re    = 1'b1;
                                prob_port.raddr = {r_cur_row, {COL_AW{1'b0}}};
                                lbl_port.re     = 1'b1;
                                lbl_port.raddr  = r_cur_row;
                                n_sum           = '0;
                                n_dcol          = '0;
                                n_state         = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PICK: begin
                lbl_port.re    = 1'b1;
                lbl_port.raddr = r_cur_row;
                n_state        = ST_LDATA;
            end
            ST_LDATA: begin
                n_res.first  = lbl_rdata.older;
                n_res.second = second ? lbl_rdata.newer : '0;
                n_res.count  = second ? 2'd2 : 2'd1;
                n_res.status = STAT_OK;
                n_state      = ST_EMIT;
            end
            ST_SCAN: begin
                // prob data belongs to column r_dcol; next column read ahead
                prob_port.re    = 1'b1;
                prob_port.raddr = {r_cur_row, dcol_nxt};
                col_port.re     = 1'b1;
                col_port.raddr  = r_dcol;
                if (sum_next >= SUM_BITS'(r_thresh)) begin
                    n_state = ST_NOTE;
                end else if ({1'b0, r_dcol} == cols_eff - COLCNT_W'(1)) begin
                    n_res   = '{first: '0, second: '0, count: 2'd0,
                                status: STAT_NOT_REACHED};
                    n_state = ST_EMIT;
                end else begin
                    n_sum  = sum_next;
                    n_dcol = dcol_nxt;
                end
            end
            ST_NOTE: begin
                // label read data still holds the current row
                n_note         = col_rdata;
                n_prev_newer   = lbl_rdata.newer;
                lbl_port.re    = 1'b1;
                lbl_port.raddr = '0;
                n_si           = '0;
                n_found        = '0;
                n_found_v      = 1'b0;
                n_state        = ST_SEARCH;
            end
            ST_SEARCH: begin
                lbl_port.re    = 1'b1;
                lbl_port.raddr = si_nxt;
                if ({1'b0, r_si} == rows_eff - ROWCNT_W'(1)) begin
                    n_res.first  = r_note;
                    n_res.second = '0;
                    n_res.count  = 2'd1;
                    if (found_v) begin
                        n_res.status = STAT_OK;
                        n_cur_row    = found_idx;
                    end else begin
                        n_res.status = STAT_NO_ROW;
                        n_cur_row    = '0;
                        n_hist       = 1'b0;
                    end
                    n_state = ST_EMIT;
                end else begin
                    n_si      = si_nxt;
                    n_found   = found_idx;
                    n_found_v = found_v;
                end
            end
            ST_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o       = r_res;
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hist    <= 1'b0;
            r_cur_row <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hist    <= n_hist;
            r_cur_row <= n_cur_row;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thresh     <= n_thresh;
        r_sum        <= n_sum;
        r_dcol       <= n_dcol;
        r_si         <= n_si;
        r_note       <= n_note;
        r_prev_newer <= n_prev_newer;
        r_found      <= n_found;
        r_found_v    <= n_found_v;
        r_res        <= n_res;
        r_o          <= n_o;
    end

    assign o_valid       = r_o_valid;
    assign o_first_note  = r_o.first;
    assign o_second_note = r_o.second;
    assign o_note_count  = r_o.count;
    assign o_status      = r_o.status;

    `MCNS_ASSERT(a_scan_in_range, i_clk, i_rst_n, (r_state == ST_SCAN) |-> ({1'b0, r_dcol} < cols_eff))
    `MCNS_ASSERT(a_search_in_range, i_clk, i_rst_n, (r_state == ST_SEARCH) |-> ({1'b0, r_si} < rows_eff))
    `MCNS_ASSERT(a_walk_needs_history, i_clk, i_rst_n, ((r_state == ST_LDATA) || (r_state == ST_SCAN) || (r_state == ST_SEARCH)) |-> r_hist)
    `MCNS_ASSERT(a_miss_no_notes, i_clk, i_rst_n, (r_o_valid && (r_o.status == STAT_NOT_REACHED)) |-> (r_o.count == 2'd0))
    `MCNS_ASSERT_NEXT(a_emit_waits, i_clk, i_rst_n, (r_state == ST_EMIT) && r_o_valid && !i_ready, (r_state == ST_EMIT) && r_o_valid)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import mcns_pkg::*;

    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int N_PHASES         = 8;
    localparam int RANDOM_PER_PHASE = 20;

    localparam logic [2:0] ACT_BOGUS_FIRST = 3'd5;
    localparam logic [2:0] ACT_BOGUS_LAST  = 3'd7;
    localparam logic [1:0] CFG_SPARE       = 2'd3;

    typedef struct packed {
        logic [2:0]           action;
        logic [ROWCNT_W-1:0]  row;
        logic [COLCNT_W-1:0]  col;
        logic [PROB_BITS-1:0] prob;
        t_note                older;
        t_note                newer;
        logic [PROB_BITS-1:0] frac;
    } t_note_cmd;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [2:0]             i_action = '0;
    logic [ROWCNT_W-1:0]    i_row_index = '0;
    logic [COLCNT_W-1:0]    i_column_index = '0;
    logic [PROB_BITS-1:0]   i_probability = '0;
    logic [NOTE_BITS-1:0]   i_label_note = '0;
    logic [NOTE_BITS-1:0]   i_label_second_note = '0;
    logic [PROB_BITS-1:0]   i_random_fraction = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [NOTE_BITS-1:0]   o_first_note;
    logic [NOTE_BITS-1:0]   o_second_note;
    logic [1:0]             o_note_count;
    logic [1:0]             o_status;

    markov_chain_note_sampler i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_action            (i_action),
        .i_row_index         (i_row_index),
        .i_column_index      (i_column_index),
        .i_probability       (i_probability),
        .i_label_note        (i_label_note),
        .i_label_second_note (i_label_second_note),
        .i_random_fraction   (i_random_fraction),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_first_note        (o_first_note),
        .o_second_note       (o_second_note),
        .o_note_count        (o_note_count),
        .o_status            (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sampler state as the bench sees it
    logic [PROB_BITS-1:0] prob_mem [MAX_ROWS][MAX_COLUMNS];
    t_note                row_old_mem [MAX_ROWS];
    t_note                row_new_mem [MAX_ROWS];
    t_note                col_mem [MAX_COLUMNS];
    int unsigned          cur_row;
    bit                   history;
    logic [1:0]           order_reg;
    logic [7:0]           rows_reg;
    logic [6:0]           cols_reg;

    t_note_cmd cmd_q [$];
    t_result   notes_due_q [$];

    logic item_taken = 1'b0;
    logic result_taken = 1'b0;
    bit   item_held;
    bit   rdy_now;
    bit   send_burst;
    bit   recv_burst;
    int   send_wait;
    int   recv_wait;
    int   quiet_cycles;
    int   mismatches;
    int   items_sent;
    int   starts_seen;
    int   steps_ok;
    int   short_sums;
    int   unmatched;

    t_note_cmd cur_cmd;
    t_note_cmd seen_cmd;
    t_result   due;
    t_result   want;
    t_note     palette [8];

    logic [7:0] phase_order [N_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd2, 8'd1, 8'd2, 8'd1};
    logic [7:0] phase_rows  [N_PHASES] = '{8'd2, 8'd255, 8'd0, 8'd3, 8'd3, 8'd5, 8'd8, 8'd16};
    logic [7:0] phase_cols  [N_PHASES] = '{8'd200, 8'd1, 8'd0, 8'd2, 8'd12, 8'd6, 8'd4, 8'd3};

    function automatic int unsigned rows_used();
        if (rows_reg < 1) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    function automatic int unsigned cols_used();
        if (cols_reg < 1) return 1;
        if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return 32'(cols_reg);
    endfunction

    // returns 1 when the item yields a result
    function automatic bit sample_next_note(input t_note_cmd c, output t_result res);
        int unsigned nrows, ncols, pick, cur, found, sum, i, j;
        t_note       note, prev;
        bit          second, hit;
        nrows  = rows_used();
        ncols  = cols_used();
        second = (order_reg == ORDER_SECOND);
        res    = '0;
        case (c.action)
            ACT_LOAD_PROB: begin
                if (c.row >= 1 && c.row <= MAX_ROWS && c.col >= 1 && c.col <= MAX_COLUMNS)
                    prob_mem[c.row - 1][c.col - 1] = c.prob;
                return 1'b0;
            end
            ACT_LOAD_ROW: begin
                if (c.row >= 1 && c.row <= MAX_ROWS) begin
                    row_old_mem[c.row - 1] = c.older;
                    row_new_mem[c.row - 1] = c.newer;
                end
                return 1'b0;
            end
            ACT_LOAD_COL: begin
                if (c.col >= 1 && c.col <= MAX_COLUMNS) col_mem[c.col - 1] = c.older;
                return 1'b0;
            end
            ACT_RESTART: begin
                cur_row = 0;
                history = 1'b0;
                return 1'b0;
            end
            ACT_GENERATE: ;
            default: return 1'b0;
        endcase

        if (!history) begin
            pick    = (c.frac * nrows) >> PROB_BITS;
            cur_row = pick + 1;
            history = 1'b1;
            res.first = row_old_mem[pick];
            if (second) begin
                res.second = row_new_mem[pick];
                res.count  = 2'd2;
            end else begin
                res.count = 2'd1;
            end
            starts_seen++;
            return 1'b1;
        end

        cur = (cur_row >= 1 && cur_row <= MAX_ROWS) ? cur_row - 1 : 0;
        sum = 0;
        for (j = 0; j < ncols; j++) begin
            sum += prob_mem[cur][j];
            if (sum >= c.frac) begin
                note  = col_mem[j];
                prev  = row_new_mem[cur];
                found = 0;
                // last matching row wins
                for (i = 0; i < nrows; i++) begin
                    if (second)
                        hit = (row_old_mem[i] == prev) && (row_new_mem[i] == note);
                    else
                        hit = (row_old_mem[i] == note);
                    if (hit) found = i + 1;
                end
                res.first = note;
                res.count = 2'd1;
                if (found != 0) begin
                    cur_row = found;
                    res.status = STAT_OK;
                    steps_ok++;
                end else begin
                    res.status = STAT_NO_ROW;
                    cur_row = 0;
                    history = 1'b0;
                    unmatched++;
                end
                return 1'b1;
            end
        end
        // threshold never reached: history stays
        res.status = STAT_NOT_REACHED;
        short_sums++;
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [9:0] exp_v, input logic [9:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
            mismatches++;
        end
    endtask

    function automatic int draw_send_gap();
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        return send_burst ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic int draw_recv_wait();
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        return recv_burst ? 0 : $urandom_range(0, 13);
    endfunction

    // driver: one item held on the input channel at a time
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            item_held = 1'b0;
            send_wait = 0;
        end else begin
            if (item_held && item_taken) item_held = 1'b0;
            if (!item_held && cmd_q.size() != 0) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else begin
                    cur_cmd = cmd_q.pop_front();
                    i_action            <= cur_cmd.action;
                    i_row_index         <= cur_cmd.row;
                    i_column_index      <= cur_cmd.col;
                    i_probability       <= cur_cmd.prob;
                    i_label_note        <= cur_cmd.older;
                    i_label_second_note <= cur_cmd.newer;
                    i_random_fraction   <= cur_cmd.frac;
                    item_held = 1'b1;
                    send_wait = draw_send_gap();
                end
            end
            i_valid <= item_held;
        end
    end

    // receiver stalls: the wait runs down only while a result is offered
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rdy_now   = 1'b0;
            recv_wait = 0;
        end else begin
            if (rdy_now && result_taken) begin
                rdy_now   = 1'b0;
                recv_wait = draw_recv_wait();
            end
            if (!rdy_now) begin
                if (recv_wait == 0) rdy_now = 1'b1;
                else if (o_valid) recv_wait--;
            end
            i_ready <= rdy_now;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken   <= 1'b0;
            result_taken <= 1'b0;
            quiet_cycles = 0;
            cur_row      = 0;
            history      = 1'b0;
            order_reg    = 2'd1;
            rows_reg     = 8'd1;
            cols_reg     = 7'd1;
        end else begin
            item_taken   <= i_valid && o_ready;
            result_taken <= o_valid && i_ready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CHAIN_ORDER: order_reg = i_cfg_data[1:0];
                    CFG_ROWS:        rows_reg  = i_cfg_data[7:0];
                    CFG_COLS:        cols_reg  = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (notes_due_q.size() == 0) begin
                    $display("%0t: result with none due: first %0d second %0d count %0d status %0d",
                             $time, o_first_note, o_second_note, o_note_count, o_status);
                    mismatches++;
                end else begin
                    want = notes_due_q.pop_front();
                    check_field("first_note", want.first, o_first_note);
                    check_field("second_note", want.second, o_second_note);
                    check_field("note_count", 10'(want.count), 10'(o_note_count));
                    check_field("status", 10'(want.status), 10'(o_status));
                end
            end
            if (i_valid && o_ready) begin
                items_sent++;
                seen_cmd = '{action: i_action, row: i_row_index, col: i_column_index,
                             prob: i_probability, older: i_label_note,
                             newer: i_label_second_note, frac: i_random_fraction};
                if (sample_next_note(seen_cmd, due)) notes_due_q.push_back(due);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("markov_chain_note_sampler: mismatch");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [2:0] action, input logic [7:0] row,
                             input logic [6:0] col, input logic [15:0] prob,
                             input t_note older, input t_note newer, input logic [15:0] frac);
        t_note_cmd c;
        c = '{action: action, row: row, col: col, prob: prob,
              older: older, newer: newer, frac: frac};
        cmd_q.push_back(c);
    endtask

    function automatic t_note rand_note();
        if ($urandom_range(0, 4) == 0) return t_note'($urandom_range(0, 999));
        return palette[$urandom_range(0, 7)];
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 11))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'd0;
            3: return 16'($urandom_range(1, 1023));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // sender waits for every result, then the block gets time to settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || item_held || notes_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // every probability a generate can read under the current settings
    task automatic queue_table_fill();
        int unsigned nr, nc, r, c, shift;
        nr = rows_used();
        nc = cols_used();
        for (r = 1; r <= MAX_ROWS; r++) begin
            if (r <= nr || (history && r == cur_row)) begin
                shift = $urandom_range(0, 9);
                for (c = 1; c <= nc; c++)
                    queue_cmd(ACT_LOAD_PROB, 8'(r), 7'(c),
                              16'($urandom_range(0, 16'hFFFF >> shift)), 0, 0, 0);
            end
        end
    endtask

    task automatic queue_random_cmd();
        t_note_cmd   c;
        int          sel;
        int unsigned nr, nc;
        nr  = rows_used();
        nc  = cols_used();
        sel = $urandom_range(0, 99);
        c.action = ACT_GENERATE;
        c.row    = 8'($urandom_range(0, 255));
        c.col    = 7'($urandom_range(0, 127));
        c.prob   = 16'($urandom_range(0, 65535));
        c.older  = t_note'($urandom_range(0, 999));
        c.newer  = t_note'($urandom_range(0, 999));
        c.frac   = 16'($urandom_range(1, 65535));
        if (sel < 55) begin
            c.frac = rand_frac();
        end else if (sel < 60) begin
            c.action = ACT_RESTART;
        end else if (sel < 75) begin
            c.action = ACT_LOAD_PROB;
            c.row    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, MAX_ROWS))
                                                   : 8'($urandom_range(1, nr));
            c.col    = 7'($urandom_range(1, nc));
            c.prob   = 16'($urandom_range(0, 16'hFFFF >> $urandom_range(0, 9)));
        end else if (sel < 85) begin
            c.action = ACT_LOAD_ROW;
            c.row    = 8'($urandom_range(1, nr));
            c.older  = rand_note();
            c.newer  = rand_note();
        end else if (sel < 93) begin
            c.action = ACT_LOAD_COL;
            c.col    = 7'($urandom_range(1, nc));
            c.older  = rand_note();
        end else if (sel < 97) begin
            c.action = 3'($urandom_range(ACT_BOGUS_FIRST, ACT_BOGUS_LAST));
        end else begin
            // load aimed outside the table
            c.action = 3'($urandom_range(ACT_LOAD_PROB, ACT_LOAD_COL));
            c.row    = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_ROWS + 1, 255));
            c.col    = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(MAX_COLUMNS + 1, 127));
            if (c.action == ACT_LOAD_PROB && $urandom_range(0, 1)) c.row = 1;
        end
        cmd_q.push_back(c);
    endtask

    initial begin
        int p, k, r, c;
        palette[0] = 10'd0;
        palette[1] = 10'd999;
        for (k = 2; k < 8; k++) palette[k] = t_note'($urandom_range(0, 999));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one row, one column: exact hits, short sums, unmatched notes
        queue_cmd(ACT_LOAD_ROW, 1, 0, 0, 10'd999, 10'd0, 0);
        queue_cmd(ACT_LOAD_COL, 0, 1, 0, 10'd999, 0, 0);
        queue_cmd(ACT_LOAD_PROB, 1, 1, 16'hFFFF, 0, 0, 0);
        queue_cmd(ACT_LOAD_ROW, 0, 0, 0, 10'd5, 10'd5, 0);
        queue_cmd(ACT_LOAD_ROW, 8'hFF, 0, 0, 10'd5, 10'd5, 0);
        queue_cmd(ACT_LOAD_COL, 0, 0, 0, 10'd5, 0, 0);
        queue_cmd(ACT_LOAD_COL, 0, 7'h7F, 0, 10'd5, 0, 0);
        queue_cmd(ACT_LOAD_PROB, MAX_ROWS + 1, 1, 0, 0, 0, 0);
        queue_cmd(ACT_LOAD_PROB, 1, MAX_COLUMNS + 1, 0, 0, 0, 0);
        queue_cmd(ACT_BOGUS_FIRST, 1, 1, 0, 10'd5, 10'd5, 16'hFFFF);
        queue_cmd(ACT_BOGUS_LAST, 1, 1, 0, 10'd5, 10'd5, 0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'd0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'hFFFF);
        queue_cmd(ACT_RESTART, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'd1);
        queue_cmd(ACT_LOAD_PROB, 1, 1, 16'd0, 0, 0, 0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'hFFFF);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'd0);
        queue_cmd(ACT_LOAD_COL, 0, 1, 0, 10'd0, 0, 0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'd0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'hFFFF);
        queue_cmd(ACT_LOAD_PROB, 1, 1, 16'd1, 0, 0, 0);
        queue_cmd(ACT_GENERATE, 0, 0, 0, 0, 0, 16'd1);

        // every label gets written before the wider settings
        for (r = 1; r <= MAX_ROWS; r++)
            queue_cmd(ACT_LOAD_ROW, 8'(r), 0, 0, rand_note(), rand_note(), 0);
        for (c = 1; c <= MAX_COLUMNS; c++)
            queue_cmd(ACT_LOAD_COL, 0, 7'(c), 0, rand_note(), 0, 0);

        for (p = 0; p < N_PHASES; p++) begin
            wait_drained();
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_CHAIN_ORDER;
            i_cfg_data  <= phase_order[p];
            @(negedge i_clk);
            i_cfg_index <= CFG_ROWS;
            i_cfg_data  <= phase_rows[p];
            @(negedge i_clk);
            i_cfg_index <= CFG_COLS;
            i_cfg_data  <= phase_cols[p];
            if (p == 3) begin
                @(negedge i_clk);
                i_cfg_index <= CFG_SPARE;
                i_cfg_data  <= CFG_W'($urandom_range(0, 255));
            end
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            queue_table_fill();
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (p == 1 && k == RANDOM_PER_PHASE / 2) wait_drained();
                queue_random_cmd();
            end
        end

        wait_drained();
        $display("%0d items over %0d settings; %0d fresh starts, %0d steps matched",
                 items_sent, N_PHASES + 1, starts_seen, steps_ok);
        $display("%0d sums short of the threshold, %0d notes with no matching row",
                 short_sums, unmatched);
        if (mismatches == 0)
            $display("markov_chain_note_sampler: match");
        else
            $display("markov_chain_note_sampler: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mcns_pkg.sv
rtl/mcns_prob_store.sv
rtl/mcns_label_store.sv
rtl/markov_chain_note_sampler.sv
bench/tb.sv
